@@ hdl/dimmer_pkg.sv @@
// Package for the two-LED push-button dimmer.
// Holds the register indices, reset values, mode codes and the configuration bundle.
// No dependencies.
`timescale 1ns / 1ps

package dimmer_pkg;

  localparam int unsigned DUTY_BITS_DEF       = 16;
  localparam int unsigned HOLD_COUNT_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 11;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL   = 3'd5;

  localparam logic [15:0]       PRESS_TICKS_RST = 16'd100;
  localparam logic [15:0]       HOLD_TICKS_RST  = 16'd2000;
  localparam logic [15:0]       STEP_TICKS_RST  = 16'd500;
  localparam logic [STEP_W-1:0] DUTY_STEP_RST   = 11'd10;
  localparam logic [15:0]       DUTY_FLOOR_RST  = 16'd0;
  localparam logic [15:0]       DUTY_CEIL_RST   = 16'd1000;

  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLUE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WHITE = 2'd2;

  typedef struct packed {
    logic [15:0]       press_ticks;
    logic [15:0]       hold_ticks;
    logic [15:0]       step_ticks;
    logic [STEP_W-1:0] duty_step;
    logic [15:0]       duty_floor;
    logic [15:0]       duty_ceil;
  } cfg_t;

endpackage

@@ hdl/dimmer_cfg.sv @@
// Configuration register file of the dimmer.
// Depends on dimmer_pkg for the register indices, reset values and cfg_t.
`timescale 1ns / 1ps

module dimmer_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dimmer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dimmer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output dimmer_pkg::cfg_t                   cfg_o
);
  import dimmer_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRESS_TICKS: cfg_d.press_ticks = cfg_wdata_i;
        REG_HOLD_TICKS:  cfg_d.hold_ticks  = cfg_wdata_i;
        REG_STEP_TICKS:  cfg_d.step_ticks  = cfg_wdata_i;
        REG_DUTY_STEP:   cfg_d.duty_step   = cfg_wdata_i[STEP_W-1:0];
        REG_DUTY_FLOOR:  cfg_d.duty_floor  = cfg_wdata_i;
        REG_DUTY_CEIL:   cfg_d.duty_ceil   = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_ticks <= PRESS_TICKS_RST;
      cfg_q.hold_ticks  <= HOLD_TICKS_RST;
      cfg_q.step_ticks  <= STEP_TICKS_RST;
      cfg_q.duty_step   <= DUTY_STEP_RST;
      cfg_q.duty_floor  <= DUTY_FLOOR_RST;
      cfg_q.duty_ceil   <= DUTY_CEIL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/dimmer_core.sv @@
// Per-tick state update of the dimmer: mode, press counting, ramp timing and duties.
// The LED output and mode registers double as the result register.
// Depends on dimmer_pkg for cfg_t, the mode codes and the field widths.
`timescale 1ns / 1ps

module dimmer_core #(
  parameter int unsigned DUTY_BITS       = dimmer_pkg::DUTY_BITS_DEF,
  parameter int unsigned HOLD_COUNT_BITS = dimmer_pkg::HOLD_COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             held_i,
  input  dimmer_pkg::cfg_t                 cfg_i,
  output logic [dimmer_pkg::LEVEL_W-1:0]   blue_level_o,
  output logic [dimmer_pkg::LEVEL_W-1:0]   white_level_o,
  output logic [dimmer_pkg::MODE_W-1:0]    led_mode_o
);
  import dimmer_pkg::*;

  localparam int unsigned AW = ((DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W) + 1;
  localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

  logic [MODE_W-1:0]          mode_q, mode_d;
  logic [HOLD_COUNT_BITS-1:0] held_cnt_q, held_cnt_d;
  logic                       dimming_q, dimming_d;
  logic                       pending_q, pending_d;
  logic [15:0]                timer_q, timer_d;
  logic [DUTY_BITS-1:0]       blue_duty_q, blue_duty_d;
  logic [DUTY_BITS-1:0]       white_duty_q, white_duty_d;
  logic                       blue_dark_q, blue_dark_d;
  logic                       white_dark_q, white_dark_d;
  logic [DUTY_BITS-1:0]       blue_out_q, blue_out_d;
  logic [DUTY_BITS-1:0]       white_out_q, white_out_d;

  logic [DUTY_BITS-1:0]       lo, hi, d_cur, applied, base, duty_new, out_new;
  logic [AW-1:0]              lo_plus, d_plus;
  logic                       sel_blue, dark_cur, dark_new, out_wr;
  logic                       room_cur, room_oth, do_begin, from_applied;
  logic [15:0]                timer_dec;
  logic [HOLD_COUNT_BITS-1:0] cnt_inc;
  logic [MODE_W-1:0]          mode_next;

  always_comb begin
    lo       = DUTY_BITS'(cfg_i.duty_floor);
    hi       = DUTY_BITS'(cfg_i.duty_ceil);
    sel_blue = (mode_q == MODE_BLUE);
    d_cur    = sel_blue ? blue_duty_q : white_duty_q;
    dark_cur = sel_blue ? blue_dark_q : white_dark_q;

    lo_plus = AW'(lo) + AW'(cfg_i.duty_step);
    d_plus  = AW'(d_cur) + AW'(cfg_i.duty_step);
    if (dark_cur) begin
      applied = (AW'(d_cur) > lo_plus) ? DUTY_BITS'(d_plus - AW'(cfg_i.duty_step)
                                                     - AW'(cfg_i.duty_step)) : lo;
    end else begin
      applied = (d_plus < AW'(hi)) ? DUTY_BITS'(d_plus) : hi;
    end

    timer_dec    = (timer_q != 16'd0) ? timer_q - 16'd1 : 16'd0;
    from_applied = pending_q && (timer_dec == 16'd0);
    base         = from_applied ? applied : d_cur;
    room_cur     = dark_cur ? (base > lo) : (base < hi);
    room_oth     = dark_cur ? (base < hi) : (base > lo);

    cnt_inc   = (held_cnt_q != HOLD_MAX) ? held_cnt_q + 1'b1 : held_cnt_q;
    mode_next = (mode_q == MODE_BLUE) ? MODE_WHITE :
                (mode_q == MODE_WHITE) ? MODE_OFF : MODE_BLUE;

    mode_d       = mode_q;
    held_cnt_d   = held_cnt_q;
    dimming_d    = dimming_q;
    pending_d    = pending_q;
    timer_d      = timer_q;
    blue_duty_d  = blue_duty_q;
    white_duty_d = white_duty_q;
    blue_dark_d  = blue_dark_q;
    white_dark_d = white_dark_q;
    blue_out_d   = blue_out_q;
    white_out_d  = white_out_q;
    duty_new     = d_cur;
    dark_new     = dark_cur;
    out_new      = base;
    out_wr       = 1'b0;
    do_begin     = 1'b0;

    if (adv_i) begin
      if (held_i) begin
        if (dimming_q) begin
          if (pending_q) begin
            timer_d = timer_dec;
            if (timer_dec == 16'd0) begin
              duty_new = applied;
              do_begin = 1'b1;
            end
          end else begin
            do_begin = 1'b1;
          end
        end else begin
          held_cnt_d = cnt_inc;
          if ((cnt_inc >= HOLD_COUNT_BITS'(cfg_i.hold_ticks)) && (mode_q != MODE_OFF)) begin
            dimming_d = 1'b1;
            do_begin  = 1'b1;
          end
        end
        if (do_begin) begin
          if (room_cur || room_oth) begin
            out_wr    = 1'b1;
            timer_d   = cfg_i.step_ticks;
            pending_d = 1'b1;
            dark_new  = room_cur ? dark_cur : !dark_cur;
          end else begin
            pending_d = 1'b0;
          end
        end
      end else begin
        if (dimming_q) begin
          if (pending_q) begin
            duty_new = applied;
            if (dark_cur && (applied <= lo)) begin
              dark_new = 1'b0;
            end else if (!dark_cur && (applied >= hi)) begin
              dark_new = 1'b1;
            end
          end
          dimming_d = 1'b0;
          pending_d = 1'b0;
          timer_d   = 16'd0;
        end else if (held_cnt_q >= HOLD_COUNT_BITS'(cfg_i.press_ticks)) begin
          mode_d = mode_next;
        end
        held_cnt_d = '0;
      end

      if (sel_blue) begin
        blue_duty_d = duty_new;
        blue_dark_d = dark_new;
        if (out_wr) begin
          blue_out_d = out_new;
        end
      end else begin
        white_duty_d = duty_new;
        white_dark_d = dark_new;
        if (out_wr) begin
          white_out_d = out_new;
        end
      end

      if (!held_i && !dimming_q && (held_cnt_q >= HOLD_COUNT_BITS'(cfg_i.press_ticks))) begin
        blue_out_d  = (mode_next == MODE_BLUE) ? blue_duty_q : '0;
        white_out_d = (mode_next == MODE_WHITE) ? white_duty_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      held_cnt_q   <= '0;
      dimming_q    <= 1'b0;
      pending_q    <= 1'b0;
      timer_q      <= 16'd0;
      blue_duty_q  <= DUTY_BITS'(DUTY_CEIL_RST);
      white_duty_q <= DUTY_BITS'(DUTY_CEIL_RST);
      blue_dark_q  <= 1'b1;
      white_dark_q <= 1'b1;
      blue_out_q   <= '0;
      white_out_q  <= '0;
    end else begin
      mode_q       <= mode_d;
      held_cnt_q   <= held_cnt_d;
      dimming_q    <= dimming_d;
      pending_q    <= pending_d;
      timer_q      <= timer_d;
      blue_duty_q  <= blue_duty_d;
      white_duty_q <= white_duty_d;
      blue_dark_q  <= blue_dark_d;
      white_dark_q <= white_dark_d;
      blue_out_q   <= blue_out_d;
      white_out_q  <= white_out_d;
    end
  end

  assign blue_level_o  = LEVEL_W'(blue_out_q);
  assign white_level_o = LEVEL_W'(white_out_q);
  assign led_mode_o    = mode_q;

endmodule

@@ hdl/two_led_push_button_dimmer.sv @@
// Top level of the two-LED push-button dimmer: request handshakes, input register,
// configuration registers and the per-tick state update.
// Depends on dimmer_pkg, dimmer_cfg and dimmer_core.
`timescale 1ns / 1ps

// One request carries one tick of the button level and yields one request with the blue
// and white PWM compare levels and the LED mode. A new tick is taken every clock cycle
// while the output is not stalled; the tick waits in the input register, and the state
// update then runs it into the LED and mode registers, which are the result register,
// once the output is free. A stalled result holds the input register, and the input
// stops being taken once both registers are full. The user writes configuration through
// the plain write port only while no tick is in flight; the block does not enforce it.

module two_led_push_button_dimmer #(
  parameter int unsigned DUTY_BITS       = dimmer_pkg::DUTY_BITS_DEF,
  parameter int unsigned HOLD_COUNT_BITS = dimmer_pkg::HOLD_COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dimmer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dimmer_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_held_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dimmer_pkg::LEVEL_W-1:0]    blue_level_o,
  output logic [dimmer_pkg::LEVEL_W-1:0]    white_level_o,
  output logic [dimmer_pkg::MODE_W-1:0]     led_mode_o
);
  import dimmer_pkg::*;

  cfg_t cfg;
  logic in_valid_q, in_valid_d;
  logic held_q, held_d;
  logic out_valid_q, out_valid_d;
  logic out_free, adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_comb begin
    in_valid_d  = in_valid_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      held_d     = button_held_i;
    end
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  dimmer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dimmer_core #(
    .DUTY_BITS       (DUTY_BITS),
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .held_i        (held_q),
    .cfg_i         (cfg),
    .blue_level_o  (blue_level_o),
    .white_level_o (white_level_o),
    .led_mode_o    (led_mode_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/dimmer_chk.sv @@
// Port-level checker for the two-LED push-button dimmer, bound to the top level.
// Depends on dimmer_pkg for the mode codes and field widths.
`timescale 1ns / 1ps

module dimmer_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [dimmer_pkg::LEVEL_W-1:0]    blue_level_o,
  input logic [dimmer_pkg::LEVEL_W-1:0]    white_level_o,
  input logic [dimmer_pkg::MODE_W-1:0]     led_mode_o
);
  import dimmer_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(blue_level_o)
      && $stable(white_level_o) && $stable(led_mode_o))
    else $error("result changed while stalled");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_mode_o == MODE_OFF) || (led_mode_o == MODE_BLUE)
      || (led_mode_o == MODE_WHITE))
    else $error("illegal LED mode");

  a_blue_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (led_mode_o != MODE_BLUE) |-> blue_level_o == '0)
    else $error("blue lit outside blue mode");

  a_white_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (led_mode_o != MODE_WHITE) |-> white_level_o == '0)
    else $error("white lit outside white mode");

endmodule

bind two_led_push_button_dimmer dimmer_chk u_dimmer_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .blue_level_o  (blue_level_o),
  .white_level_o (white_level_o),
  .led_mode_o    (led_mode_o)
);
